[src/bdpt_pkg.sv]
// ----------------------------------------------------------------------------
// bdpt_pkg
// Shared types and constants for the button debounce and press timer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdpt_pkg;

	localparam int TIME_WIDTH_DEF  = 32;
	localparam int COUNT_WIDTH_DEF = 8;

	localparam int DEBOUNCE_W = 8;
	localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 8'd40;

	typedef enum logic [1:0] {
		ST_UP      = 2'd0,
		ST_FALLING = 2'd1,
		ST_DOWN    = 2'd2,
		ST_RISING  = 2'd3
	} bdpt_state_t;

	typedef struct packed {
		logic debounced_down;
		logic press_event;
		logic release_event;
	} bdpt_flags_t;

endpackage

[src/button_debounce_press_timer_unit.sv]
// ----------------------------------------------------------------------------
// button_debounce_press_timer_unit
// Debounces an active-low button and times each press, one word per tick.
// A word accepted is registered in the input stage, processed by the state
// machine as it moves on to the result stage, and its result is shown from
// there until taken. One word per cycle while the result stage is not stalled.
// Reset: state up, counters, press time and duration cleared, threshold 40.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_debounce_press_timer_unit #(
	parameter int TIME_WIDTH  = bdpt_pkg::TIME_WIDTH_DEF,
	parameter int COUNT_WIDTH = bdpt_pkg::COUNT_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [bdpt_pkg::DEBOUNCE_W-1:0] cfg_wr_data,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            pin_level,
	input  logic [TIME_WIDTH-1:0]           now_time,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            debounced_down,
	output logic                            press_event,
	output logic                            release_event,
	output logic [TIME_WIDTH-1:0]           press_duration
);
	import bdpt_pkg::*;

	logic [DEBOUNCE_W-1:0] threshold_q;
	logic                  valid_s1;
	logic                  pin_s1;
	logic [TIME_WIDTH-1:0] now_s1;
	logic                  valid_s2;
	bdpt_flags_t           flags_s2;
	logic [TIME_WIDTH-1:0] duration_s2;
	bdpt_flags_t           flags;
	logic [TIME_WIDTH-1:0] duration;
	logic                  adv_s2;
	logic                  in_take;

	assign adv_s2   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s2;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= DEBOUNCE_RESET;
		end else if (cfg_wr_en) begin
			threshold_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_take) valid_s1 <= 1'b1;
			else if (adv_s2) valid_s1 <= 1'b0;
			if (adv_s2) valid_s2 <= 1'b1;
			else if (!out_stall) valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			pin_s1 <= pin_level;
			now_s1 <= now_time;
		end
		if (adv_s2) begin
			flags_s2    <= flags;
			duration_s2 <= duration;
		end
	end

	bdpt_fsm #(
		.TIME_WIDTH  (TIME_WIDTH),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (adv_s2),
		.pin_level (pin_s1),
		.now_time  (now_s1),
		.threshold (threshold_q),
		.flags     (flags),
		.duration  (duration)
	);

	assign out_valid      = valid_s2;
	assign debounced_down = flags_s2.debounced_down;
	assign press_event    = flags_s2.press_event;
	assign release_event  = flags_s2.release_event;
	assign press_duration = duration_s2;

`ifndef SYNTHESIS
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && in_stall |=> valid_s1 && $stable(now_s1) && $stable(pin_s1))
		else $error("input stage word lost while stalled");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && out_stall |=> valid_s2 && $stable(duration_s2) && $stable(flags_s2))
		else $error("result word changed while stalled");

	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(flags_s2.press_event && flags_s2.release_event))
		else $error("press and release in one word");
`endif

endmodule

[src/bdpt_fsm.sv]
// ----------------------------------------------------------------------------
// bdpt_fsm
// Debounce state machine with counters, press timestamp and duration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdpt_fsm #(
	parameter int TIME_WIDTH  = bdpt_pkg::TIME_WIDTH_DEF,
	parameter int COUNT_WIDTH = bdpt_pkg::COUNT_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              step_en,
	input  logic                              pin_level,
	input  logic [TIME_WIDTH-1:0]             now_time,
	input  logic [bdpt_pkg::DEBOUNCE_W-1:0]   threshold,
	output bdpt_pkg::bdpt_flags_t             flags,
	output logic [TIME_WIDTH-1:0]             duration
);
	import bdpt_pkg::*;

	localparam int CMP_W = (COUNT_WIDTH > DEBOUNCE_W) ? COUNT_WIDTH : DEBOUNCE_W;

	bdpt_state_t            state_q, state_d;
	logic [COUNT_WIDTH-1:0] falling_q, falling_d;
	logic [COUNT_WIDTH-1:0] rising_q, rising_d;
	logic [TIME_WIDTH-1:0]  press_time_q, press_time_d;
	logic [TIME_WIDTH-1:0]  duration_q, duration_d;
	logic [TIME_WIDTH-1:0]  elapsed;
	logic                   fall_expired;
	logic                   rise_expired;

	assign fall_expired = CMP_W'(falling_q) >= CMP_W'(threshold);
	assign rise_expired = CMP_W'(rising_q) >= CMP_W'(threshold);
	assign elapsed      = now_time - press_time_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_UP;
			falling_q    <= '0;
			rising_q     <= '0;
			press_time_q <= '0;
			duration_q   <= '0;
		end else if (step_en) begin
			state_q      <= state_d;
			falling_q    <= falling_d;
			rising_q     <= rising_d;
			press_time_q <= press_time_d;
			duration_q   <= duration_d;
		end
	end

	always_comb begin
		state_d             = state_q;
		falling_d           = falling_q;
		rising_d            = rising_q;
		press_time_d        = press_time_q;
		duration_d          = duration_q;
		flags.press_event   = 1'b0;
		flags.release_event = 1'b0;
		case (state_q)
			ST_UP: begin
				if (!pin_level) state_d = ST_FALLING;
			end
			ST_DOWN: begin
				if (pin_level) state_d = ST_RISING;
			end
			ST_FALLING: begin
				if (fall_expired) begin
					if (!pin_level) begin
						state_d           = ST_DOWN;
						press_time_d      = now_time;
						flags.press_event = 1'b1;
					end else begin
						state_d = ST_UP;
					end
					falling_d = COUNT_WIDTH'(1);
				end else begin
					falling_d = falling_q + 1'b1;
				end
			end
			ST_RISING: begin
				if (rise_expired) begin
					if (pin_level) begin
						state_d             = ST_UP;
						duration_d          = elapsed;
						flags.release_event = (elapsed != '0);
					end else begin
						state_d = ST_DOWN;
					end
					rising_d = COUNT_WIDTH'(1);
				end else begin
					rising_d = rising_q + 1'b1;
				end
			end
			default: begin
				state_d = state_q;
			end
		endcase
		flags.debounced_down = (state_d == ST_DOWN) || (state_d == ST_RISING);
	end

	assign duration = duration_d;

`ifndef SYNTHESIS
	a_up_exit: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && state_q == ST_UP |=> state_q == ST_UP || state_q == ST_FALLING)
		else $error("illegal exit from up");

	a_down_exit: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && state_q == ST_DOWN |=> state_q == ST_DOWN || state_q == ST_RISING)
		else $error("illegal exit from down");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!step_en |=> $stable(state_q) && $stable(press_time_q) && $stable(duration_q))
		else $error("state changed without a word");
`endif

endmodule

[sim/tb_button_debounce_press_timer_unit.sv]
// ----------------------------------------------------------------------------
// tb_button_debounce_press_timer_unit
// Self-checking bench for the debounce and press timer. A scoreboard object
// keeps its own copy of the debounce state machine, works out each tick's
// flags and duration, and compares every result word in order. A short
// directed run covers bounces, zero-length and wrapped presses at a zero
// threshold. Random press and release sequences then run over a range of
// thresholds under several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_button_debounce_press_timer_unit;

	import bdpt_pkg::*;

	localparam int TW          = TIME_WIDTH_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_HOLD   = 300;
	localparam int N_PHASES    = 8;

	typedef struct packed {
		bdpt_flags_t   flags;
		logic [TW-1:0] duration;
	} tick_update_t;

	class press_timer_scoreboard;
		bdpt_state_t             st;
		logic [COUNT_WIDTH_DEF-1:0] fall_cnt;
		logic [COUNT_WIDTH_DEF-1:0] rise_cnt;
		logic [DEBOUNCE_W-1:0]   thresh;
		logic [TW-1:0]           press_t;
		logic [TW-1:0]           duration;
		tick_update_t            due_updates[$];
		int                      errors;
		int                      checked;
		int                      presses;
		int                      releases;
		int                      zero_releases;

		function new();
			st            = ST_UP;
			fall_cnt      = '0;
			rise_cnt      = '0;
			thresh        = DEBOUNCE_RESET;
			press_t       = '0;
			duration      = '0;
			errors        = 0;
			checked       = 0;
			presses       = 0;
			releases      = 0;
			zero_releases = 0;
		endfunction

		function void set_threshold(logic [DEBOUNCE_W-1:0] value);
			thresh = value;
		endfunction

		function int pending();
			return due_updates.size();
		endfunction

		// one debounce tick for an accepted word
		function void note_tick(logic pin, logic [TW-1:0] now);
			tick_update_t u;
			u = '0;
			case (st)
				ST_UP: begin
					if (!pin)
						st = ST_FALLING;
				end
				ST_DOWN: begin
					if (pin)
						st = ST_RISING;
				end
				ST_FALLING: begin
					if (fall_cnt >= thresh) begin
						if (!pin) begin
							st                  = ST_DOWN;
							press_t             = now;
							u.flags.press_event = 1'b1;
							presses++;
						end else begin
							st = ST_UP;
						end
						fall_cnt = '0;
					end
					fall_cnt = fall_cnt + 1'b1;
				end
				default: begin
					if (rise_cnt >= thresh) begin
						if (pin) begin
							st       = ST_UP;
							duration = now - press_t;
							if (duration != '0) begin
								u.flags.release_event = 1'b1;
								releases++;
							end else begin
								zero_releases++;
							end
						end else begin
							st = ST_DOWN;
						end
						rise_cnt = '0;
					end
					rise_cnt = rise_cnt + 1'b1;
				end
			endcase
			u.flags.debounced_down = (st == ST_DOWN) || (st == ST_RISING);
			u.duration             = duration;
			due_updates.push_back(u);
		endfunction

		function void compare_field(string name, logic [TW-1:0] want, logic [TW-1:0] got);
			if (got !== want) begin
				$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_tick(tick_update_t got);
			tick_update_t want;
			if (due_updates.size() == 0) begin
				$display("%0t ns: result word with none due, got %0h", $time, got);
				errors++;
				return;
			end
			want = due_updates.pop_front();
			checked++;
			compare_field("debounced_down", TW'(want.flags.debounced_down),
				TW'(got.flags.debounced_down));
			compare_field("press_event", TW'(want.flags.press_event),
				TW'(got.flags.press_event));
			compare_field("release_event", TW'(want.flags.release_event),
				TW'(got.flags.release_event));
			compare_field("press_duration", want.duration, got.duration);
		endfunction
	endclass

	logic                  clk         = 1'b0;
	logic                  arst_n      = 1'b0;
	logic                  cfg_wr_en   = 1'b0;
	logic [DEBOUNCE_W-1:0] cfg_wr_data = '0;
	logic                  in_valid    = 1'b0;
	logic                  in_stall;
	logic                  pin_level   = 1'b1;
	logic [TW-1:0]         now_time    = '0;
	logic                  out_valid;
	logic                  out_stall   = 1'b0;
	logic                  debounced_down;
	logic                  press_event;
	logic                  release_event;
	logic [TW-1:0]         press_duration;

	press_timer_scoreboard sb = new();
	tick_update_t          seen_update;

	int            cycles       = 0;
	int            words_sent   = 0;
	int            send_idle_pct = 0;
	int            stall_pct    = 0;
	int            holds_asked  = 0;
	int            holds_done   = 0;
	logic [TW-1:0] cur_time     = '0;

	int unsigned phase_thr[N_PHASES] = '{40, 2, 255, 0, 5, 1, 3, 12};
	int          mode_send[4]        = '{0, 76, 0, 21};
	int          mode_stall[4]       = '{0, 0, 76, 21};

	button_debounce_press_timer_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.pin_level      (pin_level),
		.now_time       (now_time),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.debounced_down (debounced_down),
		.press_event    (press_event),
		.release_event  (release_event),
		.press_duration (press_duration)
	);

	always #6 clk = ~clk;

	assign seen_update = {debounced_down, press_event, release_event, press_duration};

	// accepted words and results, sampled at the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_tick(seen_update);
			if (in_valid && !in_stall)
				sb.note_tick(pin_level, now_time);
		end
	end

	// receiver: random stalls, plus a long hold when asked
	initial begin
		forever begin
			@(posedge clk);
			if (holds_asked != holds_done) begin
				holds_done++;
				out_stall <= 1'b1;
				repeat (LONG_HOLD - 1) @(posedge clk);
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// timeout
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
		$display("Simulation FAILED");
		$finish;
	end

	function automatic logic [TW-1:0] next_time();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 78)
			cur_time = cur_time + 1'b1;
		else if (r < 88)
			cur_time = cur_time;
		else if (r < 95)
			cur_time = $urandom();
		else
			cur_time = {TW{1'b1}} - $urandom_range(3);
		return cur_time;
	endfunction

	task automatic send_word(logic pin, logic [TW-1:0] t);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_valid  <= 1'b1;
		pin_level <= pin;
		now_time  <= t;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_threshold(logic [DEBOUNCE_W-1:0] value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		sb.set_threshold(value);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int unsigned thr;
		int unsigned n;
		int          phase_len;
		int          start_words;
		int          mode;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero threshold, bounces, zero-length and wrapped presses
		write_threshold(8'd0);
		send_word(1'b0, 32'h0000_0000);
		send_word(1'b0, 32'h0000_0000);
		send_word(1'b1, 32'h0000_0005);
		send_word(1'b1, 32'hFFFF_FFFF);
		send_word(1'b0, 32'd100);
		send_word(1'b0, 32'd100);
		send_word(1'b1, 32'd100);
		send_word(1'b1, 32'd100);
		send_word(1'b0, 32'd7);
		send_word(1'b1, 32'd7);
		send_word(1'b0, 32'd8);
		send_word(1'b0, 32'd9);
		send_word(1'b1, 32'd10);
		send_word(1'b0, 32'd11);
		send_word(1'b1, 32'd12);
		send_word(1'b1, 32'd12);
		send_word(1'b0, 32'hFFFF_FFF0);
		send_word(1'b0, 32'hFFFF_FFF0);
		send_word(1'b1, 32'h0000_0010);
		send_word(1'b1, 32'h0000_0010);

		// long receiver hold while words keep coming, then wait for all results
		holds_asked <= holds_asked + 1;
		cur_time = $urandom();
		repeat (40) send_word(1'($urandom_range(1)), next_time());
		drain_results();

		for (int p = 0; p < N_PHASES; p++) begin
			thr  = phase_thr[p];
			mode = p % 4;
			write_threshold(thr[DEBOUNCE_W-1:0]);
			send_idle_pct = mode_send[mode];
			stall_pct    <= mode_stall[mode];
			phase_len     = 160 + int'(thr);
			start_words   = words_sent;
			while (words_sent - start_words < phase_len) begin
				if ($urandom_range(99) < 20) begin
					// bouncing pin
					n = $urandom_range(8, 1);
					repeat (n) send_word(1'($urandom_range(1)), next_time());
				end else begin
					n = thr + 2 + $urandom_range(3);
					if ($urandom_range(99) < 10)
						n = $urandom_range(thr + 1, 1);
					repeat (n) send_word(1'b0, next_time());
					n = thr + 2 + $urandom_range(3);
					if ($urandom_range(99) < 10)
						n = $urandom_range(thr + 1, 1);
					repeat (n) send_word(1'b1, next_time());
				end
			end
			drain_results();
			stall_pct <= 0;
		end

		drain_results();
		$display("%0d words over %0d thresholds from 0 to 255, %0d results checked",
			words_sent, N_PHASES, sb.checked);
		$display("%0d presses, %0d timed releases, %0d zero-length releases",
			sb.presses, sb.releases, sb.zero_releases);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d results outstanding", sb.errors, sb.pending());
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
